[hw/rtl/vas_pkg.sv]
// Shared types and constants for the voice allocator with oldest-note stealing.
// No dependencies; imported by vas_mem, vas_ctrl and the top level.
`default_nettype none

package vas_pkg;

	localparam int VOICES_DEF = 8;
	localparam int SLOT_W     = 6;
	localparam int NOTE_W     = 8;
	localparam int AGE_W      = 8;
	localparam int STATUS_W   = 3;

	localparam logic [NOTE_W-1:0] NOTE_EMPTY = 8'hFF;
	localparam logic [AGE_W-1:0]  AGE_EMPTY  = 8'hFF;
	localparam logic [AGE_W-1:0]  AGE_MAX    = 8'd254;

	localparam logic CMD_PUSH   = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_FILLED   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

	// one voice slot as stored in memory
	typedef struct packed {
		logic              busy;
		logic [NOTE_W-1:0] note;
		logic [AGE_W-1:0]  age;
	} entry_t;

	localparam entry_t EMPTY_ENTRY = '{busy: 1'b0, note: NOTE_EMPTY, age: AGE_EMPTY};

	// controller -> memory request
	typedef struct packed {
		logic              rd_en;
		logic [SLOT_W-1:0] rd_addr;
		logic              wr_en;
		logic [SLOT_W-1:0] wr_addr;
		entry_t            wr_data;
	} mem_req_t;

	// one result item
	typedef struct packed {
		logic [SLOT_W-1:0]   slot;
		logic [STATUS_W-1:0] status;
		logic [NOTE_W-1:0]   evicted;
	} result_t;

endpackage

`default_nettype wire

[hw/rtl/vas_mem.sv]
// Voice slot memory: one write and one registered read per cycle.
// Per-entry valid flops make never-written slots read as empty. Uses vas_pkg.
`default_nettype none

module vas_mem #(
	parameter int VOICES = vas_pkg::VOICES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  vas_pkg::mem_req_t req,
	output vas_pkg::entry_t   rd_entry
);
	import vas_pkg::*;

	localparam int AW = (VOICES > 1) ? $clog2(VOICES) : 1;

	entry_t            mem_q [VOICES];
	logic [VOICES-1:0] valid_q;
	entry_t            rd_q;
	logic              rd_ok_q;

	logic [AW-1:0] ra;
	logic [AW-1:0] wa;

	assign ra = req.rd_addr[AW-1:0];
	assign wa = req.wr_addr[AW-1:0];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[wa] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_q <= mem_q[ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				valid_q[wa] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_ok_q <= valid_q[ra];
			end
		end
	end

	assign rd_entry = rd_ok_q ? rd_q : EMPTY_ENTRY;

endmodule

`default_nettype wire

[hw/rtl/vas_ctrl.sv]
// Allocation sequencer: scan pass, then a clearing write for a remove or an aging pass and final slot write.
// Drives vas_mem through a mem_req_t; uses vas_pkg.
`default_nettype none

module vas_ctrl #(
	parameter int VOICES = vas_pkg::VOICES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           in_cmd,
	input  logic [vas_pkg::NOTE_W-1:0]     in_freq,
	output vas_pkg::mem_req_t              mem_req,
	input  vas_pkg::entry_t                rd_entry,
	output logic                           res_valid,
	input  logic                           res_ready,
	output vas_pkg::result_t               res
);
	import vas_pkg::*;

	localparam int            AW   = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam logic [AW-1:0] LAST = AW'(VOICES - 1);

	typedef enum logic [2:0] {
		IDLE, SCAN, SCAN_END, DECIDE, AGE, AGE_END, FILL, DONE
	} state_t;

	state_t            state_q;
	logic              cmd_q;
	logic [NOTE_W-1:0] freq_q;
	logic [AW-1:0]     cnt_q;
	logic              rd_vld_s1;
	logic [AW-1:0]     rd_idx_s1;
	logic              hit_q;
	logic [AW-1:0]     hit_idx_q;
	logic              empty_q;
	logic [AW-1:0]     empty_idx_q;
	logic              have_old_q;
	logic [AGE_W-1:0]  old_age_q;
	logic [AW-1:0]     old_idx_q;
	logic [NOTE_W-1:0] old_note_q;
	result_t           res_q;

	logic              rd_en;
	logic [AGE_W-1:0]  age_inc;
	logic              scanning;
	logic [AW-1:0]     target;

	assign rd_en    = (state_q == SCAN) || (state_q == AGE);
	assign scanning = rd_vld_s1 && ((state_q == SCAN) || (state_q == SCAN_END));
	assign age_inc  = (rd_entry.age < AGE_MAX) ? rd_entry.age + AGE_W'(1) : AGE_MAX;
	assign target   = empty_q ? empty_idx_q : old_idx_q;

	always_comb begin
		mem_req         = '0;
		mem_req.rd_en   = rd_en;
		mem_req.rd_addr = SLOT_W'(cnt_q);
		case (state_q)
			AGE, AGE_END: begin
				// age write-back follows in the cycle after the read
				if (rd_vld_s1 && rd_entry.busy) begin
					mem_req.wr_en       = 1'b1;
					mem_req.wr_addr     = SLOT_W'(rd_idx_s1);
					mem_req.wr_data     = rd_entry;
					mem_req.wr_data.age = age_inc;
				end
			end
			DECIDE: begin
				if (cmd_q == CMD_REMOVE && hit_q) begin
					mem_req.wr_en   = 1'b1;
					mem_req.wr_addr = SLOT_W'(hit_idx_q);
					mem_req.wr_data = EMPTY_ENTRY;
				end
			end
			FILL: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = SLOT_W'(target);
				mem_req.wr_data = '{busy: 1'b1, note: freq_q, age: '0};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			cmd_q       <= CMD_PUSH;
			freq_q      <= '0;
			cnt_q       <= '0;
			rd_vld_s1   <= 1'b0;
			rd_idx_s1   <= '0;
			hit_q       <= 1'b0;
			hit_idx_q   <= '0;
			empty_q     <= 1'b0;
			empty_idx_q <= '0;
			have_old_q  <= 1'b0;
			old_age_q   <= '0;
			old_idx_q   <= '0;
			old_note_q  <= '0;
			res_q       <= '0;
		end else begin
			rd_vld_s1 <= rd_en;
			rd_idx_s1 <= cnt_q;

			if (scanning) begin
				if (rd_entry.busy && rd_entry.note == freq_q && !hit_q) begin
					hit_q     <= 1'b1;
					hit_idx_q <= rd_idx_s1;
				end
				if (!rd_entry.busy) begin
					empty_q     <= 1'b1;
					empty_idx_q <= rd_idx_s1;
				end
				if (rd_entry.busy && (!have_old_q || rd_entry.age > old_age_q)) begin
					have_old_q <= 1'b1;
					old_age_q  <= rd_entry.age;
					old_idx_q  <= rd_idx_s1;
					old_note_q <= rd_entry.note;
				end
			end

			case (state_q)
				IDLE: begin
					if (in_valid) begin
						cmd_q      <= in_cmd;
						freq_q     <= in_freq;
						cnt_q      <= '0;
						hit_q      <= 1'b0;
						empty_q    <= 1'b0;
						have_old_q <= 1'b0;
						state_q    <= SCAN;
					end
				end
				SCAN: begin
					if (cnt_q == LAST) begin
						state_q <= SCAN_END;
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				SCAN_END: state_q <= DECIDE;
				DECIDE: begin
					if (cmd_q == CMD_REMOVE) begin
						res_q   <= hit_q ? result_t'{slot: SLOT_W'(hit_idx_q),
						                             status: ST_REMOVED, evicted: '0}
						                 : result_t'{slot: '0, status: ST_NOTFOUND,
						                             evicted: '0};
						state_q <= DONE;
					end else if (hit_q) begin
						res_q   <= result_t'{slot: SLOT_W'(hit_idx_q), status: ST_PRESENT,
						                     evicted: '0};
						state_q <= DONE;
					end else begin
						cnt_q   <= '0;
						state_q <= AGE;
					end
				end
				AGE: begin
					if (cnt_q == LAST) begin
						state_q <= AGE_END;
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				AGE_END: state_q <= FILL;
				FILL: begin
					res_q   <= empty_q ? result_t'{slot: SLOT_W'(empty_idx_q),
					                               status: ST_FILLED, evicted: '0}
					                   : result_t'{slot: SLOT_W'(old_idx_q),
					                               status: ST_REPLACED, evicted: old_note_q};
					state_q <= DONE;
				end
				DONE: begin
					if (res_ready) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == IDLE);
	assign res_valid = (state_q == DONE);
	assign res       = res_q;

endmodule

`default_nettype wire

[hw/rtl/voice_allocator_oldest_steal.sv]
// Top level of the voice allocator with oldest-note stealing.
// Instantiates vas_mem and vas_ctrl; uses vas_pkg.
//
// Usage:
//   Slave channel carries note events: s_tuser[0] is the command (0 push,
//   1 remove), s_tdata[7:0] the note frequency code.
//   Master channel returns exactly one result item per event:
//   m_tdata[5:0] slot, m_tdata[13:6] evicted frequency, m_tuser[2:0] status
//   (filled, replaced, already present, removed, not found).
// Timing:
//   One event at a time. A scan pass reads every slot through the memory's
//   single read port, one slot a cycle. Remove and duplicate push produce a
//   result after the scan pass; a push of a new note adds an aging pass and
//   a slot write. The result then moves to the output register once that
//   register can take it. s_tready rises again as soon as the result has
//   left the sequencer, so the next event can start while the output still
//   waits.
// Reset:
//   arst_n clears the slot valid flops, so every slot reads empty; no
//   clearing pass is needed.
// Backpressure:
//   If m_tready stays low the result holds in the output register, and a
//   second result waits in the sequencer, which then accepts nothing more.
`default_nettype none

module voice_allocator_oldest_steal #(
	parameter int VOICES = vas_pkg::VOICES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] note_freq
	input  logic [0:0]  s_tuser,   // [0] command

	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [5:0] slot, [13:6] evicted_freq, [15:14] zero
	output logic [2:0]  m_tuser    // [2:0] status
);
	import vas_pkg::*;

	mem_req_t mem_req;
	entry_t   rd_entry;
	logic     res_valid;
	logic     res_ready;
	result_t  res;

	// output register
	logic     out_vld_q;
	result_t  out_res_q;

	vas_mem #(
		.VOICES(VOICES)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (mem_req),
		.rd_entry (rd_entry)
	);

	vas_ctrl #(
		.VOICES(VOICES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (s_tuser[0]),
		.in_freq   (s_tdata),
		.mem_req   (mem_req),
		.rd_entry  (rd_entry),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// the register takes a new item when empty or draining this cycle
	assign res_ready = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_ready) begin
			out_vld_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_res_q <= res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {2'b00, out_res_q.evicted, out_res_q.slot};
	assign m_tuser  = out_res_q.status;

	// sequencer never takes an item while a result is still pending in it
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !res_valid)
		else $error("input ready while a result is pending");

	// memory is only written while an item is in progress
	a_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.wr_en |-> !s_tready)
		else $error("slot write while idle");

	// only a replacement reports an evicted frequency
	a_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ST_REPLACED) |-> (m_tdata[13:6] == '0))
		else $error("evicted frequency without replacement");

	// a result handed over is shown on the next cycle
	a_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready) |=> m_tvalid)
		else $error("result lost at output register");

endmodule

`default_nettype wire

[verif/tb_voice_allocator_oldest_steal.sv]
// Testbench for voice_allocator_oldest_steal: directed table, then random note events.
// Checks each result against the predictor or a typed row; needs vas_pkg and the RTL.
`timescale 1ns / 100ps

module tb_voice_allocator_oldest_steal;
	import vas_pkg::*;

	localparam int NV         = VOICES_DEF;
	localparam int N_RANDOM   = 2000;
	localparam int CYCLE_MAX  = 600000;  // watchdog limit, well above the slowest correct run
	localparam int DRAIN_WAIT = 2 * NV + 10;
	localparam int HOLD_LEN   = 300;     // long output hold to back the block up

	// one row of the directed table; res is only used when pinned is set
	typedef struct packed {
		logic    cmd;
		logic [NOTE_W-1:0] freq;
		logic    pinned;
		result_t res;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] note_freq
	logic [0:0]  s_tuser;   // [0] command
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // [5:0] slot, [13:6] evicted_freq, [15:14] zero
	logic [2:0]  m_tuser;   // [2:0] status

	// typed-in expectation travels with the item, registered like the data
	logic    pin_flag;
	result_t pin_res;

	// scoreboard copy of the voice slots
	logic              held_busy [NV];
	logic [NOTE_W-1:0] held_note [NV];
	logic [AGE_W-1:0]  held_age  [NV];

	result_t   pending_results[$];
	stim_row_t dir_rows[$];

	int  n_errors;
	int  n_events;
	int  status_seen [5];
	int  cycle_cnt;
	bit  hold_req;
	bit  hold_done;
	bit  sink_quiet;

	voice_allocator_oldest_steal u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// 4 ns clock
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predict the result of one note event and advance the slot copy.
	// Matching only looks at busy slots, so the empty code 255 is an ordinary note.
	function automatic result_t alloc_note(logic cmd, logic [NOTE_W-1:0] freq);
		result_t          r;
		int               hit;
		int               empty_i;
		int               old_i;
		logic [AGE_W-1:0] old_age;
		bit               have_old;
		int               i;
		r        = '0;
		hit      = -1;
		empty_i  = -1;
		old_i    = 0;
		old_age  = '0;
		have_old = 1'b0;
		for (i = 0; i < NV; i++)
			if (hit < 0 && held_busy[i] && held_note[i] == freq)
				hit = i;

		if (cmd == CMD_REMOVE) begin
			if (hit < 0) begin
				r.status = ST_NOTFOUND;
			end else begin
				held_busy[hit] = 1'b0;
				held_note[hit] = NOTE_EMPTY;
				held_age[hit]  = AGE_EMPTY;
				r.slot   = SLOT_W'(hit);
				r.status = ST_REMOVED;
			end
			return r;
		end

		// duplicate push: nothing ages
		if (hit >= 0) begin
			r.slot   = SLOT_W'(hit);
			r.status = ST_PRESENT;
			return r;
		end

		// oldest is picked on ages before this step's aging; lowest index wins ties
		for (i = 0; i < NV; i++) begin
			if (!held_busy[i]) begin
				empty_i = i;
			end else begin
				if (!have_old || held_age[i] > old_age) begin
					old_age  = held_age[i];
					old_i    = i;
					have_old = 1'b1;
				end
				if (held_age[i] < AGE_MAX)
					held_age[i] = held_age[i] + 1'b1;
			end
		end

		if (empty_i >= 0) begin
			r.slot   = SLOT_W'(empty_i);
			r.status = ST_FILLED;
			old_i    = empty_i;
		end else begin
			r.slot    = SLOT_W'(old_i);
			r.status  = ST_REPLACED;
			r.evicted = held_note[old_i];
		end
		held_busy[old_i] = 1'b1;
		held_note[old_i] = freq;
		held_age[old_i]  = '0;
		return r;
	endfunction

	// Scoreboard: predict on input accept, compare on output accept.
	// Everything sampled at the rising edge, before this edge's updates land.
	always @(posedge clk) begin
		result_t want;
		result_t got;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				want = alloc_note(s_tuser[0], s_tdata);
				if (pin_flag)
					want = pin_res;
				pending_results.push_back(want);
				n_events++;
			end
			if (m_tvalid && m_tready) begin
				got.slot    = m_tdata[5:0];
				got.evicted = m_tdata[13:6];
				got.status  = m_tuser;
				if (got.status <= ST_NOTFOUND)
					status_seen[got.status]++;
				if (pending_results.size() == 0) begin
					n_errors++;
					$display("%0t: unexpected result slot=%0d status=%0d evicted=%0d",
						$time, got.slot, got.status, got.evicted);
				end else begin
					want = pending_results.pop_front();
					if (got.slot !== want.slot) begin
						n_errors++;
						$display("%0t: slot mismatch: expected %0d, got %0d",
							$time, want.slot, got.slot);
					end
					if (got.status !== want.status) begin
						n_errors++;
						$display("%0t: status mismatch: expected %0d, got %0d",
							$time, want.status, got.status);
					end
					if (got.evicted !== want.evicted) begin
						n_errors++;
						$display("%0t: evicted_freq mismatch: expected %0d, got %0d",
							$time, want.evicted, got.evicted);
					end
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_MAX) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_cnt, pending_results.size());
			$display("tb_voice_allocator_oldest_steal: FAIL");
			$finish;
		end
	end

	// Result sink: random stall per item, quiet stretches, and one long hold
	// while the sender keeps pushing, so both result stages fill and s_tready drops.
	initial begin
		int stall;
		m_tready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				stall     = HOLD_LEN;
				hold_done = 1'b1;
			end else begin
				if ($urandom_range(0, 29) == 0)
					sink_quiet = !sink_quiet;
				stall = sink_quiet ? 0 : $urandom_range(0, 15);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	// One note event: optional gap, then hold valid until the handshake.
	// Valid stays high across back-to-back items, never dropped and re-raised in one step.
	task automatic send_event(logic cmd, logic [NOTE_W-1:0] freq, logic pinned,
		result_t res, int gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= freq;
		s_tuser  <= cmd;
		pin_flag <= pinned;
		pin_res  <= res;
		do @(posedge clk); while (!(s_tvalid && s_tready));
	endtask

	task automatic add_row(logic cmd, logic [NOTE_W-1:0] freq, logic pinned,
		logic [SLOT_W-1:0] slot, logic [STATUS_W-1:0] status, logic [NOTE_W-1:0] evicted);
		stim_row_t row;
		row.cmd         = cmd;
		row.freq        = freq;
		row.pinned      = pinned;
		row.res.slot    = slot;
		row.res.status  = status;
		row.res.evicted = evicted;
		dir_rows.push_back(row);
	endtask

	initial begin
		int        gap;
		int        mode;
		int        phase;
		int        phase_left;
		int        burst_left;
		int        sent;
		bit        src_quiet;
		logic      cmd;
		logic [NOTE_W-1:0] freq;
		logic [NOTE_W-1:0] churn_note;
		stim_row_t row;

		arst_n     <= 1'b0;
		s_tvalid   <= 1'b0;
		s_tdata    <= '0;
		s_tuser    <= '0;
		pin_flag   <= 1'b0;
		pin_res    <= '0;
		n_errors   = 0;
		n_events   = 0;
		hold_req   = 1'b0;
		hold_done  = 1'b0;
		sink_quiet = 1'b0;
		src_quiet  = 1'b0;
		burst_left = 0;
		churn_note = '0;
		foreach (status_seen[k]) status_seen[k] = 0;
		for (int i = 0; i < NV; i++) begin
			held_busy[i] = 1'b0;
			held_note[i] = NOTE_EMPTY;
			held_age[i]  = AGE_EMPTY;
		end

		// Directed table. Typed rows: after reset, first fills, duplicates and misses.
		add_row(CMD_REMOVE, 8'd10,  1'b1, 6'd0, ST_NOTFOUND, 8'd0);  // remove from empty
		add_row(CMD_PUSH,   8'd0,   1'b1, 6'd7, ST_FILLED,   8'd0);  // highest empty slot first
		add_row(CMD_PUSH,   8'd254, 1'b1, 6'd6, ST_FILLED,   8'd0);
		add_row(CMD_PUSH,   8'd0,   1'b1, 6'd7, ST_PRESENT,  8'd0);  // duplicate push
		add_row(CMD_REMOVE, 8'd255, 1'b1, 6'd0, ST_NOTFOUND, 8'd0);  // empty slots never match
		add_row(CMD_PUSH,   8'd255, 1'b1, 6'd5, ST_FILLED,   8'd0);  // 255 as a plain note
		add_row(CMD_PUSH,   8'd255, 1'b1, 6'd5, ST_PRESENT,  8'd0);
		add_row(CMD_REMOVE, 8'd255, 1'b1, 6'd5, ST_REMOVED,  8'd0);
		// fill up, then steal the oldest
		add_row(CMD_PUSH,   8'd1,   1'b0, 6'd0, ST_FILLED,   8'd0);
		add_row(CMD_PUSH,   8'd2,   1'b0, 6'd0, ST_FILLED,   8'd0);
		add_row(CMD_PUSH,   8'd3,   1'b0, 6'd0, ST_FILLED,   8'd0);
		add_row(CMD_PUSH,   8'd4,   1'b0, 6'd0, ST_FILLED,   8'd0);
		add_row(CMD_PUSH,   8'd5,   1'b0, 6'd0, ST_FILLED,   8'd0);
		add_row(CMD_PUSH,   8'd6,   1'b0, 6'd0, ST_FILLED,   8'd0);
		add_row(CMD_PUSH,   8'd7,   1'b0, 6'd0, ST_FILLED,   8'd0);  // steals note 0
		add_row(CMD_PUSH,   8'd8,   1'b0, 6'd0, ST_FILLED,   8'd0);  // steals note 254
		add_row(CMD_REMOVE, 8'd3,   1'b0, 6'd0, ST_REMOVED,  8'd0);
		add_row(CMD_REMOVE, 8'd3,   1'b1, 6'd0, ST_NOTFOUND, 8'd0);
		add_row(CMD_PUSH,   8'd170, 1'b0, 6'd0, ST_FILLED,   8'd0);  // into the freed slot
		add_row(CMD_PUSH,   8'd85,  1'b0, 6'd0, ST_FILLED,   8'd0);
		add_row(CMD_PUSH,   8'd128, 1'b0, 6'd0, ST_FILLED,   8'd0);
		add_row(CMD_REMOVE, 8'd7,   1'b0, 6'd0, ST_FILLED,   8'd0);
		add_row(CMD_PUSH,   8'd254, 1'b0, 6'd0, ST_FILLED,   8'd0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r]) begin
			row = dir_rows[r];
			send_event(row.cmd, row.freq, row.pinned, row.res, $urandom_range(0, 15));
		end

		// Random part in phases:
		//   0 small note pool, mixed push/remove (hits, misses, steals)
		//   1 full code range including 255 (every input bit)
		//   2 push/remove of one note while the rest sit, so ages saturate at 254
		//     and the next steals hit ties
		//   3 push-heavy small pool, constant stealing
		sent       = 0;
		phase      = 0;
		phase_left = 0;
		while (sent < N_RANDOM) begin
			if (phase_left == 0) begin
				mode       = phase % 4;
				phase_left = (mode == 2) ? 560 : 120;
				phase++;
			end
			case (mode)
				0: begin
					freq = NOTE_W'($urandom_range(0, 11));
					cmd  = ($urandom_range(0, 9) < 6) ? CMD_PUSH : CMD_REMOVE;
				end
				1: begin
					freq = NOTE_W'($urandom_range(0, 255));
					cmd  = 1'($urandom_range(0, 1));
				end
				2: begin
					if (phase_left % 2 == 0) begin
						churn_note = NOTE_W'($urandom_range(0, 255));
						cmd        = CMD_PUSH;
					end else begin
						cmd = CMD_REMOVE;
					end
					freq = churn_note;
				end
				default: begin
					freq = NOTE_W'($urandom_range(0, 20));
					cmd  = ($urandom_range(0, 9) < 8) ? CMD_PUSH : CMD_REMOVE;
				end
			endcase

			// partway in, ask the sink for its long hold and send back to back
			if (sent == 300) begin
				hold_req   = 1'b1;
				burst_left = 40;
			end
			if ($urandom_range(0, 39) == 0)
				src_quiet = !src_quiet;
			if (burst_left > 0) begin
				gap = 0;
				burst_left--;
			end else begin
				gap = src_quiet ? 0 : $urandom_range(0, 15);
			end

			send_event(cmd, freq, 1'b0, '0, gap);
			sent++;
			phase_left--;
		end
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("%0d note events: %0d filled, %0d stolen, %0d duplicate, %0d removed,",
			n_events, status_seen[ST_FILLED], status_seen[ST_REPLACED],
			status_seen[ST_PRESENT], status_seen[ST_REMOVED]);
		$display("%0d not found; age saturation phases and a %0d-cycle output hold, %0d errors",
			status_seen[ST_NOTFOUND], HOLD_LEN, n_errors);
		if (n_errors == 0)
			$display("tb_voice_allocator_oldest_steal: PASS");
		else
			$display("tb_voice_allocator_oldest_steal: FAIL");
		$finish;
	end

endmodule
